// ===== sv/tmm_pkg.sv =====
// Shared types, constants and the scale table of the tilt to MIDI note mapper.
package tmm_pkg;

  localparam int unsigned AXIS_BITS_DEF = 16;
  localparam int unsigned TILT_W        = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned OCTAVE_W      = 4;
  localparam int unsigned NOTE_W        = 7;
  localparam int unsigned VELO_W        = 7;

  localparam logic [CFG_IDX_W-1:0]  CFG_OCTAVE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_DEAD_ZONE = 1'b1;

  localparam logic [OCTAVE_W-1:0]   OCTAVE_MAX    = 4'd8;
  localparam logic [OCTAVE_W-1:0]   OCTAVE_RST    = 4'd4;
  localparam logic [CFG_DATA_W-1:0] DEAD_ZONE_RST = 16'd1000;
  localparam logic [15:0]           FULL_SCALE    = 16'd32767;
  localparam logic [VELO_W-1:0]     VELO_MAX      = 7'd127;

  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note_number;
    logic [VELO_W-1:0] velocity;
    logic              last;
  } msg_t;

  // Major scale, one step per 45-degree sector
  function automatic logic [3:0] scale_step(logic [2:0] sector);
    logic [3:0] step;
    unique case (sector)
      3'd0:    step = 4'd0;
      3'd1:    step = 4'd2;
      3'd2:    step = 4'd4;
      3'd3:    step = 4'd5;
      3'd4:    step = 4'd7;
      3'd5:    step = 4'd9;
      3'd6:    step = 4'd11;
      3'd7:    step = 4'd12;
      default: step = 4'd0;
    endcase
    return step;
  endfunction

endpackage

// ===== sv/tmm_sqsum.sv =====
// Bit-serial sum of squares: one multiplier bit of each axis per cycle.
module tmm_sqsum import tmm_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [AXIS_BITS-1:0]   abs_x_i,
  input  logic [AXIS_BITS-1:0]   abs_y_i,
  output logic                   done_o,
  output logic [2*AXIS_BITS-1:0] sum_o
);

  localparam int unsigned SumW = 2 * AXIS_BITS;
  localparam int unsigned CntW = $clog2(AXIS_BITS);

  logic [AXIS_BITS-1:0] mx_q, my_q;
  logic [SumW-1:0]      ax_q, ay_q, acc_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [SumW-1:0]      acc_d;

  always_comb begin
    acc_d = acc_q + (mx_q[0] ? ax_q : '0) + (my_q[0] ? ay_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(AXIS_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q  <= abs_x_i;
      my_q  <= abs_y_i;
      ax_q  <= SumW'(abs_x_i);
      ay_q  <= SumW'(abs_y_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mx_q  <= mx_q >> 1;
      my_q  <= my_q >> 1;
      ax_q  <= ax_q << 1;
      ay_q  <= ay_q << 1;
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

// ===== sv/tmm_isqrt.sv =====
// Restoring floor square root, one result bit per cycle.
module tmm_isqrt import tmm_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2*AXIS_BITS-1:0] radicand_i,
  output logic                   done_o,
  output logic [AXIS_BITS-1:0]   root_o
);

  localparam int unsigned SumW = 2 * AXIS_BITS;

  logic [SumW-1:0] rem_q, root_q, bit_q;
  logic [SumW-1:0] trial;
  logic            busy_q, done_q;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= radicand_i;
      root_q <= '0;
      bit_q  <= SumW'(1) << (SumW - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[AXIS_BITS-1:0];

endmodule

// ===== sv/tilt_to_midi_note_mapper.sv =====
// Top level: tilt samples and power-off events in, MIDI note messages out.
//
//   channel  signals                                         role
//   in       in_valid_i/in_ready_o, action, tilt_x, tilt_y   item in
//   out      out_valid_o/out_ready_i, note_on, note_number,  message out
//            velocity, last
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i               register write
//
// A powered sample passes through the bit-serial squarer and the serial square root, then the
// root start, the magnitude capture, the note evaluation and the output load before its first
// message shows. A power-off event with a note held has its note-off registered and then
// loaded into the output register. Each message then waits for out_ready_i. A new item is
// taken once the last message sits in the output register.
// Reset: octave 4, dead zone 1000, no note held, powered.
module tilt_to_midi_note_mapper import tmm_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [TILT_W-1:0]     tilt_x_i,
  input  logic [TILT_W-1:0]     tilt_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  note_on_o,
  output logic [NOTE_W-1:0]     note_number_o,
  output logic [VELO_W-1:0]     velocity_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_EVAL = 5'b01000,
    ST_SEND = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [OCTAVE_W-1:0]   octave_q;
  logic [CFG_DATA_W-1:0] dz_q;
  logic                  held_valid_q, held_valid_d;
  logic [NOTE_W-1:0]     held_note_q, held_note_d;
  logic                  power_on_q, power_on_d;
  logic signed [AXIS_BITS-1:0] x_q, y_q;
  logic [AXIS_BITS-1:0]  mag_q;
  msg_t                  p0_q, p0_d, p1_q, p1_d, out_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;

  logic                  accept;
  logic [AXIS_BITS-1:0]  x_in, y_in, abs_x, abs_y;
  logic                  sq_start, sq_done, rt_start, rt_done;
  logic [2*AXIS_BITS-1:0] sq_sum;
  logic [AXIS_BITS-1:0]  root;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign x_in  = tilt_x_i[AXIS_BITS-1:0];
  assign y_in  = tilt_y_i[AXIS_BITS-1:0];
  assign abs_x = x_in[AXIS_BITS-1] ? (~x_in + 1'b1) : x_in;
  assign abs_y = y_in[AXIS_BITS-1] ? (~y_in + 1'b1) : y_in;

  assign sq_start = accept && !action_i && power_on_q;
  assign rt_start = (state_q == ST_SQ) && sq_done;

  tmm_sqsum #(.AXIS_BITS(AXIS_BITS)) u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .abs_x_i (abs_x),
    .abs_y_i (abs_y),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  tmm_isqrt #(.AXIS_BITS(AXIS_BITS)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rt_start),
    .radicand_i (sq_sum),
    .done_o     (rt_done),
    .root_o     (root)
  );

  // Sector of (2x, y); boundaries go to the higher sector
  logic signed [AXIS_BITS+1:0] sx, sy;
  logic [2:0]                  sector;

  assign sx = {x_q[AXIS_BITS-1], x_q, 1'b0};
  assign sy = {{2{y_q[AXIS_BITS-1]}}, y_q};

  always_comb begin
    priority if (sy > 0) begin
      if (sx > 0) sector = (sy < sx) ? 3'd0 : 3'd1;
      else        sector = (sy > -sx) ? 3'd2 : 3'd3;
    end else if (sy == 0) begin
      sector = (sx < 0) ? 3'd4 : 3'd0;
    end else begin
      if (sx < 0) sector = (-sy < -sx) ? 3'd4 : 3'd5;
      else        sector = (-sy > sx) ? 3'd6 : 3'd7;
    end
  end

  // Note and velocity
  logic [NOTE_W-1:0] note;
  logic [15:0]       mag16, diff, qr_sum;
  logic              below;
  logic [22:0]       prod;
  logic [8:0]        quo;
  logic [VELO_W-1:0] velo;

  assign note  = {octave_q, 3'b000} + {1'b0, octave_q, 2'b00}
               + {3'b000, scale_step(sector)};
  assign mag16 = 16'(mag_q);
  assign below = mag16 < dz_q;
  assign diff  = mag16 - dz_q;
  // diff*127, then divide by 32767 as shift by 15 plus one correction
  assign prod   = {diff, 7'b0} - {7'b0, diff};
  assign qr_sum = {8'b0, prod[22:15]} + {1'b0, prod[14:0]};
  assign quo    = {1'b0, prod[22:15]} + {8'b0, (qr_sum >= FULL_SCALE)};
  assign velo   = (quo > 9'(VELO_MAX)) ? VELO_MAX : quo[VELO_W-1:0];

  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    held_valid_d = held_valid_q;
    held_note_d  = held_note_q;
    power_on_d   = power_on_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i) begin
            power_on_d = 1'b0;
            if (held_valid_q) begin
              p0_d    = '{note_on: 1'b0, note_number: held_note_q, velocity: '0, last: 1'b1};
              state_d = ST_SEND;
            end
          end else if (power_on_q) begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (sq_done) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (rt_done) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (below) begin
          if (held_valid_q) begin
            p0_d         = '{note_on: 1'b0, note_number: held_note_q, velocity: '0, last: 1'b1};
            held_valid_d = 1'b0;
            state_d      = ST_SEND;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          if (held_valid_q && held_note_q != note) begin
            p0_d = '{note_on: 1'b0, note_number: held_note_q, velocity: '0, last: 1'b0};
            p1_d = '{note_on: 1'b1, note_number: note, velocity: velo, last: 1'b1};
          end else begin
            p0_d = '{note_on: 1'b1, note_number: note, velocity: velo, last: 1'b1};
          end
          held_note_d  = note;
          held_valid_d = 1'b1;
          state_d      = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (p0_q.last) state_d = ST_IDLE;
          else           p0_d    = p1_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_valid_q <= 1'b0;
      held_note_q  <= '0;
      power_on_q   <= 1'b1;
      out_valid_q  <= 1'b0;
      octave_q     <= OCTAVE_RST;
      dz_q         <= DEAD_ZONE_RST;
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      held_note_q  <= held_note_d;
      power_on_q   <= power_on_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_OCTAVE: begin
            octave_q <= (cfg_data_i[OCTAVE_W-1:0] > OCTAVE_MAX) ? OCTAVE_MAX
                                                                : cfg_data_i[OCTAVE_W-1:0];
          end
          CFG_DEAD_ZONE: dz_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    if (accept) begin
      x_q <= x_in;
      y_q <= y_in;
    end
    if (rt_done) mag_q <= root;
    if (state_q == ST_SEND && out_load) out_q <= p0_q;
  end

  assign out_valid_o   = out_valid_q;
  assign note_on_o     = out_q.note_on;
  assign note_number_o = out_q.note_number;
  assign velocity_o    = out_q.velocity;
  assign last_o        = out_q.last;

endmodule

// ===== sv/tmm_checker.sv =====
// Port-level checks on the tilt to MIDI note mapper, bound to the top level.
module tmm_checker import tmm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              note_on_o,
  input logic [NOTE_W-1:0] note_number_o,
  input logic [VELO_W-1:0] velocity_o,
  input logic              last_o
);

  // stalled message holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable({note_on_o, note_number_o, velocity_o, last_o}))
    else $error("output item changed while stalled");

  // note-off carries zero velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !note_on_o |-> velocity_o == '0)
    else $error("note-off with nonzero velocity");

  // the only message ahead of another one is the release of the old note
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !note_on_o)
    else $error("note-on not marked last");

  // octave 8 plus the top scale step is the highest note
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> note_number_o <= 7'd108)
    else $error("note number out of range");

endmodule

bind tilt_to_midi_note_mapper tmm_checker u_tmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .note_on_o     (note_on_o),
  .note_number_o (note_number_o),
  .velocity_o    (velocity_o),
  .last_o        (last_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the tilt to MIDI note mapper: directed and random items, scoreboard.
module testbench;
  import tmm_pkg::*;

  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_POWER_OFF = 1'b1;
  localparam int   SETTLE_CYCLES = 48;   // longer than a sample's path through the mapper
  localparam int   MAX_REPORTS   = 10;
  localparam int   PHASE_ITEMS   = 135;
  localparam logic [7:0][3:0] STEP_TABLE =
    {4'd12, 4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
  localparam logic [4:0][15:0] AXIS_EXTREMES =
    {16'h8001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};

  typedef struct packed {
    logic              action;
    logic [TILT_W-1:0] x;
    logic [TILT_W-1:0] y;
  } tilt_item_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  action_i    = ACT_SAMPLE;
  logic [TILT_W-1:0]     tilt_x_i    = '0;
  logic [TILT_W-1:0]     tilt_y_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b1;
  logic                  note_on_o;
  logic [NOTE_W-1:0]     note_number_o;
  logic [VELO_W-1:0]     velocity_o;
  logic                  last_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_OCTAVE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  tilt_item_t pending_items[$];
  msg_t       expected_msgs[$];
  int         mismatches = 0;
  int         gap_left   = 0;
  int         stall_left = 0;
  logic       calm       = 1'b0;

  // predicted state of the mapper
  logic              note_held     = 1'b0;
  logic [NOTE_W-1:0] held_number   = '0;
  logic              powered       = 1'b1;
  logic [3:0]        octave_cfg    = 4'd4;
  logic [15:0]       dead_zone_cfg = 16'd1000;

  tilt_to_midi_note_mapper uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .tilt_x_i      (tilt_x_i),
    .tilt_y_i      (tilt_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .note_on_o     (note_on_o),
    .note_number_o (note_number_o),
    .velocity_o    (velocity_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint floor_root(longint n);
    longint r;
    r = longint'($sqrt(real'(n)));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  // Direction of (dx, dy) in 45-degree sectors; ties go to the higher sector.
  function automatic logic [2:0] direction_sector(int dx, int dy);
    if (dy == 0) return (dx < 0) ? 3'd4 : 3'd0;
    if (dy > 0) begin
      if (dx > 0) return (dy < dx) ? 3'd0 : 3'd1;
      return (dy > -dx) ? 3'd2 : 3'd3;
    end
    if (dx < 0) return (-dy < -dx) ? 3'd4 : 3'd5;
    return (-dy > dx) ? 3'd6 : 3'd7;
  endfunction

  function automatic msg_t make_msg(logic on, logic [NOTE_W-1:0] num, logic [VELO_W-1:0] vel);
    msg_t m;
    m = {on, num, vel, 1'b0};
    return m;
  endfunction

  function automatic void map_tilt_item(tilt_item_t it);
    msg_t              msgs[$];
    int                sx;
    int                sy;
    longint            mag;
    longint            velo;
    int                note;
    if (it.action == ACT_POWER_OFF) begin
      if (note_held) msgs.push_back(make_msg(1'b0, held_number, '0));
      powered = 1'b0;
    end else if (powered) begin
      sx  = $signed(it.x);
      sy  = $signed(it.y);
      mag = floor_root(longint'(sx) * sx + longint'(sy) * sy);
      if (mag < longint'(dead_zone_cfg)) begin
        if (note_held) msgs.push_back(make_msg(1'b0, held_number, '0));
        note_held = 1'b0;
      end else begin
        note = int'(octave_cfg) * 12 + int'(STEP_TABLE[direction_sector(2 * sx, sy)]);
        velo = (mag - longint'(dead_zone_cfg)) * 127 / 32767;
        if (velo > 127) velo = 127;
        if (note_held && held_number != NOTE_W'(note))
          msgs.push_back(make_msg(1'b0, held_number, '0));
        msgs.push_back(make_msg(1'b1, NOTE_W'(note), VELO_W'(velo)));
        held_number = NOTE_W'(note);
        note_held   = 1'b1;
      end
    end
    if (msgs.size() != 0) msgs[msgs.size() - 1].last = 1'b1;
    foreach (msgs[i]) expected_msgs.push_back(msgs[i]);
  endfunction

  function automatic void queue_item(logic act, int x, int y);
    tilt_item_t it;
    it.action = act;
    it.x      = x[15:0];
    it.y      = y[15:0];
    pending_items.push_back(it);
  endfunction

  task automatic queue_random_samples(int count);
    int lim;
    int k;
    int x;
    int y;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          x = $urandom;
          y = $urandom;
        end
        5, 6: begin
          // magnitudes around the dead zone
          lim = (dead_zone_cfg > 26000) ? 32767 : int'(dead_zone_cfg) * 5 / 4 + 4;
          x = $urandom_range(0, lim);
          y = $urandom_range(0, lim);
          if ($urandom_range(0, 1)) x = -x;
          if ($urandom_range(0, 1)) y = -y;
        end
        7: begin
          x = int'($signed(AXIS_EXTREMES[$urandom_range(0, 4)]));
          y = int'($signed(AXIS_EXTREMES[$urandom_range(0, 4)]));
        end
        default: begin
          // exactly on a sector boundary or an axis
          k = $urandom_range(1, 16383);
          case ($urandom_range(0, 5))
            0:       begin x = k;  y = 2 * k;  end
            1:       begin x = -k; y = 2 * k;  end
            2:       begin x = -k; y = -2 * k; end
            3:       begin x = k;  y = -2 * k; end
            4:       begin x = $urandom_range(0, 1) ? -2 * k : 2 * k; y = 0; end
            default: begin x = 0;  y = $urandom_range(0, 1) ? -2 * k : 2 * k; end
          endcase
        end
      endcase
      queue_item(ACT_SAMPLE, x, y);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_OCTAVE) octave_cfg = (data[3:0] > OCTAVE_MAX) ? OCTAVE_MAX : data[3:0];
    else dead_zone_cfg = data;
  endtask

  // Status is looked at on the falling edge, away from the driver's updates.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_msgs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_side
    tilt_item_t taken;
    tilt_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken = {action_i, tilt_x_i, tilt_y_i};
        map_tilt_item(taken);
        if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          action_i   <= nxt.action;
          tilt_x_i   <= nxt.x;
          tilt_y_i   <= nxt.y;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_side
    msg_t got;
    msg_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {note_on_o, note_number_o, velocity_o, last_o};
      if (expected_msgs.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected message on=%0b note=%0d vel=%0d last=%0b",
                   $time, got.note_on, got.note_number, got.velocity, got.last);
        mismatches++;
      end else begin
        want = expected_msgs.pop_front();
        if (got.note_on !== want.note_on || got.note_number !== want.note_number ||
            got.velocity !== want.velocity || got.last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch exp on/note/vel/last %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                     $time, want.note_on, want.note_number, want.velocity, want.last,
                     got.note_on, got.note_number, got.velocity, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned oct_plan[6];
    int unsigned dz_plan[6];

    // reset values: octave 4, dead zone 1000
    queue_item(ACT_SAMPLE, 0, 0);             // below dead zone, nothing held
    queue_item(ACT_SAMPLE, 32767, 0);
    queue_item(ACT_SAMPLE, 32767, 0);         // same note struck again
    queue_item(ACT_SAMPLE, 1000, 2000);       // boundaries, counter-clockwise
    queue_item(ACT_SAMPLE, 0, 5000);
    queue_item(ACT_SAMPLE, -1000, 2000);
    queue_item(ACT_SAMPLE, -32768, 0);
    queue_item(ACT_SAMPLE, -1000, -2000);
    queue_item(ACT_SAMPLE, 0, -32768);
    queue_item(ACT_SAMPLE, 1000, -2000);
    queue_item(ACT_SAMPLE, -32768, -32768);   // velocity saturates
    queue_item(ACT_SAMPLE, 32767, 32767);
    queue_item(ACT_SAMPLE, 600, 800);         // magnitude equals dead zone
    queue_item(ACT_SAMPLE, 599, 800);         // just below: release
    queue_item(ACT_SAMPLE, 10, -10);
    queue_item(ACT_SAMPLE, -1, -1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    write_reg(CFG_OCTAVE, 16'd0);
    write_reg(CFG_DEAD_ZONE, 16'd0);
    queue_item(ACT_SAMPLE, 0, 0);             // zero vector lands in sector 0
    queue_item(ACT_SAMPLE, -1, 0);
    queue_item(ACT_SAMPLE, 0, -1);
    wait_idle();

    write_reg(CFG_OCTAVE, 16'd15);            // saturates to 8
    queue_item(ACT_SAMPLE, -32768, 32767);
    queue_item(ACT_SAMPLE, 32767, -32768);
    wait_idle();

    write_reg(CFG_OCTAVE, 16'hFFF3);          // upper bits dropped
    write_reg(CFG_DEAD_ZONE, 16'hFFFF);
    queue_item(ACT_SAMPLE, -32768, -32768);   // never reaches the dead zone
    queue_item(ACT_SAMPLE, 32767, 32767);
    wait_idle();

    oct_plan = '{8, 0, 9, 2, $urandom_range(0, 15), $urandom_range(0, 15)};
    dz_plan  = '{0, 65535, 300, 20000, $urandom_range(0, 65535), $urandom_range(0, 3000)};
    foreach (oct_plan[p]) begin
      write_reg(CFG_OCTAVE, CFG_DATA_W'(oct_plan[p]));
      write_reg(CFG_DEAD_ZONE, CFG_DATA_W'(dz_plan[p]));
      queue_random_samples(PHASE_ITEMS);
      wait_idle();
    end

    // last stretch: no idling, then power off for good
    calm = 1'b1;
    write_reg(CFG_OCTAVE, CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(CFG_DEAD_ZONE, CFG_DATA_W'($urandom_range(1, 4000)));
    queue_random_samples(80);
    queue_item(ACT_SAMPLE, 32767, 0);
    if ($urandom_range(0, 1)) queue_item(ACT_SAMPLE, 0, 0);
    queue_item(ACT_POWER_OFF, $urandom, $urandom);
    queue_item(ACT_SAMPLE, -32768, 1234);     // ignored while off
    queue_item(ACT_POWER_OFF, 0, 0);          // held note released again
    queue_item(ACT_SAMPLE, $urandom, $urandom);
    wait_idle();

    if (mismatches == 0 && expected_msgs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tmm_pkg.sv
sv/tmm_sqsum.sv
sv/tmm_isqrt.sv
sv/tilt_to_midi_note_mapper.sv
sv/tmm_checker.sv
tb/testbench.sv
